[design/packbits_encoder_top_macros.svh]
// assertion macros shared by the packbits encoder modules
`ifndef PACKBITS_ENCODER_TOP_MACROS_SVH
`define PACKBITS_ENCODER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pbe_pkg.sv]
// shared types and constants of the packbits encoder
package pbe_pkg;

  localparam int unsigned MaxPacketDef = 128;
  localparam logic [8:0]  RunBase      = 9'd257;
  localparam logic [7:0]  EndMarker    = 8'd128;

  typedef enum logic [2:0] {
    SEL_LIT_HDR,
    SEL_LIT_DATA,
    SEL_RUN_HDR,
    SEL_HELD,
    SEL_MARK
  } byte_sel_e;

  typedef struct packed {
    logic      latch;
    logic      run_inc;
    logic      run_clr;
    logic      run_start;
    logic      lit_write;
    logic      lit_clr;
    logic      idx_clr;
    logic      idx_inc;
    logic      held_clr;
    byte_sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    logic match;
    logic holding;
    logic run_ge3;
    logic run_eq2;
    logic run_eq1;
    logic rfl;
    logic lc_nz;
    logic lc_last;
    logic idx_last;
  } dp_stat_t;

  typedef struct packed {
    logic push;
    logic close;
  } pk_req_t;

  typedef struct packed {
    logic push_ready;
    logic close_ready;
  } pk_ack_t;

endpackage

[design/pbe_dp.sv]
// datapath: run and literal state, literal store and output byte select
module pbe_dp #(
  parameter int unsigned MaxPacket = pbe_pkg::MaxPacketDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       data_byte_i,
  input  pbe_pkg::dp_cmd_t cmd_i,
  output pbe_pkg::dp_stat_t stat_o,
  output logic [7:0]       push_byte_o
);
  import pbe_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxPacket);
  localparam logic [7:0]  MaxW = 8'(MaxPacket);
  localparam logic [7:0]  LastW = 8'(MaxPacket - 1);

  logic [7:0]      mem_q [MaxPacket];
  logic [7:0]      rdata_q;
  logic [7:0]      byte_q;
  logic [7:0]      held_q;
  logic [7:0]      run_q;
  logic [7:0]      lc_q;
  logic            holding_q;
  logic            rfl_q;
  logic [IdxW-1:0] idx_q, idx_d;

  always_comb begin
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IdxW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      run_q     <= '0;
      lc_q      <= '0;
      holding_q <= 1'b0;
      rfl_q     <= 1'b0;
      idx_q     <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.run_start) begin
        holding_q <= 1'b1;
        held_q    <= byte_q;
        run_q     <= 8'd1;
        rfl_q     <= 1'b0;
      end else if (cmd_i.run_clr) begin
        holding_q <= 1'b0;
        run_q     <= '0;
        rfl_q     <= 1'b0;
      end else if (cmd_i.run_inc) begin
        run_q <= run_q + 8'd1;
        if (run_q == 8'd1) begin
          rfl_q <= stat_o.lc_nz;
        end
      end
      if (cmd_i.held_clr) begin
        held_q <= '0;
      end
      if (cmd_i.lit_clr) begin
        lc_q <= '0;
      end else if (cmd_i.lit_write) begin
        lc_q <= lc_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      byte_q <= data_byte_i;
    end
    if (cmd_i.lit_write) begin
      mem_q[lc_q[IdxW-1:0]] <= held_q;
    end
    rdata_q <= mem_q[idx_d];
  end

  always_comb begin
    stat_o.match    = holding_q && (data_byte_i == held_q) && (run_q < MaxW);
    stat_o.holding  = holding_q;
    stat_o.run_ge3  = run_q >= 8'd3;
    stat_o.run_eq2  = run_q == 8'd2;
    stat_o.run_eq1  = run_q == 8'd1;
    stat_o.rfl      = rfl_q;
    stat_o.lc_nz    = lc_q != 8'd0;
    stat_o.lc_last  = lc_q == LastW;
    stat_o.idx_last = 8'(idx_q) == (lc_q - 8'd1);
  end

  always_comb begin
    unique case (cmd_i.sel)
      SEL_LIT_HDR:  push_byte_o = lc_q - 8'd1;
      SEL_LIT_DATA: push_byte_o = rdata_q;
      SEL_RUN_HDR:  push_byte_o = 8'(RunBase - {1'b0, run_q});
      SEL_HELD:     push_byte_o = held_q;
      SEL_MARK:     push_byte_o = EndMarker;
      default:      push_byte_o = held_q;
    endcase
  end

endmodule

[design/pbe_packer.sv]
// packs bytes into output beats of up to eight bytes with output register
module pbe_packer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pbe_pkg::pk_req_t req_i,
  input  logic [7:0]       push_byte_i,
  output pbe_pkg::pk_ack_t ack_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [63:0]      packed_bytes_o,
  output logic [3:0]       byte_count_o,
  output logic             last_of_step_o
);
  import pbe_pkg::*;

  `include "packbits_encoder_top_macros.svh"

  logic [63:0] acc_q;
  logic [3:0]  acc_cnt_q;
  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic [3:0]  out_cnt_q;
  logic        out_last_q;
  logic        acc_full;
  logic        push_fire;
  logic        close_fire;

  always_comb begin
    acc_full          = acc_cnt_q == 4'd8;
    ack_o.push_ready  = !acc_full || !out_valid_q;
    ack_o.close_ready = (acc_cnt_q == 4'd0) || !out_valid_q;
    push_fire         = req_i.push && ack_o.push_ready;
    close_fire        = req_i.close && ack_o.close_ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      acc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_cnt_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (push_fire) begin
        if (acc_full) begin
          out_valid_q <= 1'b1;
          out_data_q  <= acc_q;
          out_cnt_q   <= acc_cnt_q;
          out_last_q  <= 1'b0;
          acc_q       <= {56'b0, push_byte_i};
          acc_cnt_q   <= 4'd1;
        end else begin
          acc_q     <= acc_q | (64'(push_byte_i) << {acc_cnt_q[2:0], 3'b000});
          acc_cnt_q <= acc_cnt_q + 4'd1;
        end
      end else if (close_fire && (acc_cnt_q != 4'd0)) begin
        out_valid_q <= 1'b1;
        out_data_q  <= acc_q;
        out_cnt_q   <= acc_cnt_q;
        out_last_q  <= 1'b1;
        acc_q       <= '0;
        acc_cnt_q   <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packed_bytes_o = out_data_q;
  assign byte_count_o   = out_cnt_q;
  assign last_of_step_o = out_last_q;

  `PBE_ASSERT_NOW(a_out_cnt_range, out_valid_q, (out_cnt_q != 4'd0) && (out_cnt_q <= 4'd8), "beat with bad byte count")
  `PBE_ASSERT_NOW(a_acc_cnt_range, 1'b1, acc_cnt_q <= 4'd8, "accumulator count overflow")
  `PBE_ASSERT_NEXT(a_full_spill, push_fire && acc_full, out_valid_q && !out_last_q && (out_cnt_q == 4'd8), "full word not spilled as non-final beat")

endmodule

[design/pbe_ctrl.sv]
// controller state machine sequencing run, literal and end marker packets
module pbe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              is_final_i,
  input  pbe_pkg::dp_stat_t stat_i,
  output pbe_pkg::dp_cmd_t  cmd_o,
  output pbe_pkg::pk_req_t  req_o,
  input  pbe_pkg::pk_ack_t  ack_i
);
  import pbe_pkg::*;

  `include "packbits_encoder_top_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_RUN_HDR,
    ST_RUN_BYTE,
    ST_APPEND,
    ST_POST_CLOSE,
    ST_POST_TAKE,
    ST_LIT_HDR,
    ST_LIT_BODY,
    ST_MARK,
    ST_FINISH
  } state_e;

  state_e     state_q, state_d;
  state_e     ret_q, ret_d;
  logic       fin_q, fin_d;
  logic       final_phase_q, final_phase_d;
  logic [1:0] left_q, left_d;

  always_comb begin
    state_d       = state_q;
    ret_d         = ret_q;
    fin_d         = fin_q;
    final_phase_d = final_phase_q;
    left_d        = left_q;
    cmd_o         = '0;
    cmd_o.sel     = SEL_HELD;
    req_o         = '0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch   = 1'b1;
          fin_d         = is_final_i;
          final_phase_d = 1'b0;
          if (stat_i.match) begin
            cmd_o.run_inc = 1'b1;
            if ((stat_i.run_ge3 || stat_i.run_eq2) && stat_i.lc_nz) begin
              state_d = ST_LIT_HDR;
              ret_d   = ST_POST_TAKE;
            end else begin
              state_d = ST_POST_TAKE;
            end
          end else begin
            state_d = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        priority if (!stat_i.holding) begin
          state_d = ST_POST_CLOSE;
        end else if (stat_i.run_ge3) begin
          state_d = ST_RUN_HDR;
        end else if (stat_i.run_eq2) begin
          if (stat_i.rfl && stat_i.lc_nz) begin
            left_d  = 2'd2;
            state_d = ST_APPEND;
          end else begin
            state_d = ST_RUN_HDR;
          end
        end else if (stat_i.run_eq1) begin
          left_d  = 2'd1;
          state_d = ST_APPEND;
        end else begin
          state_d = ST_POST_CLOSE;
        end
      end
      ST_RUN_HDR: begin
        req_o.push = 1'b1;
        cmd_o.sel  = SEL_RUN_HDR;
        if (ack_i.push_ready) begin
          state_d = ST_RUN_BYTE;
        end
      end
      ST_RUN_BYTE: begin
        req_o.push = 1'b1;
        cmd_o.sel  = SEL_HELD;
        if (ack_i.push_ready) begin
          state_d = ST_POST_CLOSE;
        end
      end
      ST_APPEND: begin
        cmd_o.lit_write = 1'b1;
        left_d          = left_q - 2'd1;
        if (stat_i.lc_last) begin
          state_d = ST_LIT_HDR;
          ret_d   = (left_q == 2'd1) ? ST_POST_CLOSE : ST_APPEND;
        end else if (left_q == 2'd1) begin
          state_d = ST_POST_CLOSE;
        end
      end
      ST_POST_CLOSE: begin
        if (!final_phase_q) begin
          cmd_o.run_start = 1'b1;
          state_d         = ST_POST_TAKE;
        end else begin
          cmd_o.run_clr = 1'b1;
          if (stat_i.lc_nz) begin
            state_d = ST_LIT_HDR;
            ret_d   = ST_MARK;
          end else begin
            state_d = ST_MARK;
          end
        end
      end
      ST_POST_TAKE: begin
        if (fin_q) begin
          final_phase_d = 1'b1;
          state_d       = ST_CLOSE;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_LIT_HDR: begin
        cmd_o.idx_clr = 1'b1;
        req_o.push    = 1'b1;
        cmd_o.sel     = SEL_LIT_HDR;
        if (ack_i.push_ready) begin
          state_d = ST_LIT_BODY;
        end
      end
      ST_LIT_BODY: begin
        req_o.push = 1'b1;
        cmd_o.sel  = SEL_LIT_DATA;
        if (ack_i.push_ready) begin
          if (stat_i.idx_last) begin
            cmd_o.lit_clr = 1'b1;
            state_d       = ret_q;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_MARK: begin
        req_o.push = 1'b1;
        cmd_o.sel  = SEL_MARK;
        if (ack_i.push_ready) begin
          cmd_o.held_clr = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        req_o.close = 1'b1;
        if (ack_i.close_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ret_q         <= ST_IDLE;
      fin_q         <= 1'b0;
      final_phase_q <= 1'b0;
      left_q        <= '0;
    end else begin
      state_q       <= state_d;
      ret_q         <= ret_d;
      fin_q         <= fin_d;
      final_phase_q <= final_phase_d;
      left_q        <= left_d;
    end
  end

  `PBE_ASSERT_NOW(a_append_left, state_q == ST_APPEND, (left_q == 2'd1) || (left_q == 2'd2), "append count out of range")
  `PBE_ASSERT_NOW(a_walk_nonempty, state_q == ST_LIT_BODY || state_q == ST_LIT_HDR, stat_i.lc_nz, "literal walk with empty store")
  `PBE_ASSERT_NEXT(a_miss_closes, (state_q == ST_IDLE) && in_valid_i && !stat_i.match, state_q == ST_CLOSE, "mismatching byte did not close run")

endmodule

[design/packbits_encoder_top.sv]
// PackBits run-length encoder, top level
//
// Input channel: one raw byte per beat (data_byte_i), is_final_i marks the
// last byte of a stream, valid/ready handshake.
// Output channel: beats of up to eight stream bytes, first byte in bits 7:0,
// byte_count_o valid bytes, last_of_step_o on the final beat caused by an
// input byte. An input byte that completes no packet gives no beat.
// Timing: the controller walks one output byte per cycle through the
// packer while the packer takes it; a literal flush walks the literal
// store one entry a cycle, also held when the packer cannot take it.
// Input ready is high only while the controller is idle. The output beat
// sits in a register; a stalled receiver holds the controller when a byte
// must go out while both that register and the eight-byte packing word
// are full, or when an input byte ends with bytes in the packing word
// while the register still waits.
// Reset: returns to idle with no run or literal pending; the literal store
// holds no reset value and is read only where written.
module packbits_encoder_top #(
  parameter int unsigned MaxPacket = pbe_pkg::MaxPacketDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        is_final_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] packed_bytes_o,
  output logic [3:0]  byte_count_o,
  output logic        last_of_step_o
);
  import pbe_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  pk_req_t    req;
  pk_ack_t    ack;
  logic [7:0] push_byte;

  pbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .is_final_i (is_final_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .req_o      (req),
    .ack_i      (ack)
  );

  pbe_dp #(
    .MaxPacket (MaxPacket)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (data_byte_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .push_byte_o (push_byte)
  );

  pbe_packer u_packer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .push_byte_i    (push_byte),
    .ack_o          (ack),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .packed_bytes_o (packed_bytes_o),
    .byte_count_o   (byte_count_o),
    .last_of_step_o (last_of_step_o)
  );

endmodule
